[hw/rtl/bt_pkg.sv]
`timescale 1ns / 1ps

package bt_pkg;

  // default list depths
  localparam int unsigned SourceDepthDefault = 64;
  localparam int unsigned TargetDepthDefault = 64;

  // field widths
  localparam int unsigned FuncW  = 2;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 1;
  // wide enough for any position or count up to a depth of 256
  localparam int unsigned CmpW   = 9;

  // item function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_XLATE  = 2'd0,
    FUNC_WR_SRC = 2'd1,
    FUNC_WR_TGT = 2'd2
  } func_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_COUNT = 1'd0,
    CFG_TARGET_COUNT = 1'd1
  } cfg_e;

  // one item as it travels down the cell row
  typedef struct packed {
    logic             vld;
    logic [FuncW-1:0] func;
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] data;
    logic             hit;
  } item_t;

endpackage

[hw/rtl/bt_cell.sv]
`timescale 1ns / 1ps

module bt_cell
  import bt_pkg::*;
#(
  parameter int unsigned POS   = 0,
  parameter int unsigned POS_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CountW-1:0] src_count_i,
  input  item_t             item_i,
  input  logic [POS_W-1:0]  pos_i,
  output item_t             item_o,
  output logic [POS_W-1:0]  pos_o
);

  logic [ByteW-1:0] entry_q, entry_d;
  logic             vld_q;
  item_t            item_q, item_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             wr_here;
  logic             in_range;
  logic             match;

  // write of this cell's source entry
  assign wr_here  = item_i.vld && (item_i.func == FUNC_WR_SRC)
                    && ({{(CmpW-IdxW){1'b0}}, item_i.idx} == CmpW'(POS));
  assign in_range = CmpW'(POS) < {{(CmpW-CountW){1'b0}}, src_count_i};

  // first match wins, zero byte never matches
  assign match = item_i.vld && (item_i.func == FUNC_XLATE) && !item_i.hit
                 && in_range && (item_i.data != '0) && (entry_q == item_i.data);

  always_comb begin
    entry_d = wr_here ? item_i.data : entry_q;
    item_d  = item_i;
    pos_d   = pos_i;
    if (match) begin
      item_d.hit = 1'b1;
      pos_d      = POS_W'(POS);
    end
  end

  // source entry, undefined until written
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      item_q  <= item_d;
      pos_q   <= pos_d;
    end
  end

  // item valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= item_d.vld;
    end
  end

  always_comb begin
    item_o     = item_q;
    item_o.vld = vld_q;
  end
  assign pos_o = pos_q;

endmodule

[hw/rtl/bt_lookup.sv]
`timescale 1ns / 1ps

module bt_lookup
  import bt_pkg::*;
#(
  parameter int unsigned TARGET_DEPTH = TargetDepthDefault,
  parameter int unsigned POS_W        = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CountW-1:0] tgt_count_i,
  input  item_t             item_i,
  input  logic [POS_W-1:0]  pos_i,
  output logic              out_valid_o,
  output logic [ByteW-1:0]  out_byte_o
);

  localparam int unsigned AddrW = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;

  logic [ByteW-1:0] tgt_mem [TARGET_DEPTH];
  logic [ByteW-1:0] rd_q;
  logic [ByteW-1:0] byte_q;
  logic             hit_q;
  logic             out_valid_q, out_valid_d;
  logic [CmpW-1:0]  tcnt;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  rd_addr_ext;
  logic [CmpW-1:0]  wr_addr_ext;
  logic             wr_en;
  logic             is_xlate;

  // clamp the count to the depth and the position to the last entry
  assign tcnt = ({{(CmpW-CountW){1'b0}}, tgt_count_i} > CmpW'(TARGET_DEPTH))
                ? CmpW'(TARGET_DEPTH) : {{(CmpW-CountW){1'b0}}, tgt_count_i};
  assign pos_ext     = CmpW'(pos_i);
  assign rd_addr_ext = (pos_ext >= tcnt) ? (tcnt - CmpW'(1)) : pos_ext;

  assign wr_addr_ext = {{(CmpW-IdxW){1'b0}}, item_i.idx};
  assign wr_en       = en_i && item_i.vld && (item_i.func == FUNC_WR_TGT)
                       && (wr_addr_ext < CmpW'(TARGET_DEPTH));

  // a hit with an empty target list deletes the byte
  assign is_xlate    = item_i.vld && (item_i.func == FUNC_XLATE);
  assign out_valid_d = is_xlate && (!item_i.hit || (tcnt != '0));

  // target list memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tgt_mem[wr_addr_ext[AddrW-1:0]] <= item_i.data;
    end
    if (en_i) begin
      rd_q   <= tgt_mem[rd_addr_ext[AddrW-1:0]];
      byte_q <= item_i.data;
      hit_q  <= item_i.hit;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = hit_q ? rd_q : byte_q;

endmodule

[hw/rtl/byte_transliterator.sv]
`timescale 1ns / 1ps

// byte transliterator, tr style
// input channel (in_valid_i/in_ready_o) carries items: func_i selects
// translate, write source entry or write target entry; entry_index_i is
// the list position of a write, byte_value_i the byte or the character.
// config channel (cfg_valid_i/cfg_ready_o) sets source_count (index 0)
// and target_count (index 1); it is always ready.
// the source list lives in a row of SOURCE_DEPTH cells, one entry each;
// every item walks the row one cell per cycle unless the row holds, and
// the first matching cell tags it with its position. the target list is
// a memory read at the end of the row.
// an item passes through every cell register and then the lookup
// registers; throughput: one item per cycle unless the row holds.
// writes ride the row too, so they stay in order with translates.
// a translate item gives one output item unless it hits with an empty
// target list; write items give none.
// when out_ready_i is low with an output waiting, the whole row holds and
// in_ready_o drops.
// reset clears counts and valid bits; list contents are undefined until
// written.

module byte_transliterator
  import bt_pkg::*;
#(
  parameter int unsigned SOURCE_DEPTH = SourceDepthDefault,
  parameter int unsigned TARGET_DEPTH = TargetDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [IdxW-1:0]    entry_index_i,
  input  logic [ByteW-1:0]   byte_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   out_byte_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  localparam int unsigned PosW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;

  logic              en;
  logic [CountW-1:0] src_count_q;
  logic [CountW-1:0] tgt_count_q;
  item_t             chain   [SOURCE_DEPTH+1];
  logic [PosW-1:0]   pos_row [SOURCE_DEPTH+1];

  // the row moves unless a finished output is stalled
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_count_q <= '0;
      tgt_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE_COUNT: src_count_q <= cfg_data_i;
        CFG_TARGET_COUNT: tgt_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item entering the row
  assign chain[0]   = {in_valid_i, func_i, entry_index_i, byte_value_i, 1'b0};
  assign pos_row[0] = '0;

  // row of source cells
  for (genvar k = 0; k < SOURCE_DEPTH; k++) begin : g_cell
    bt_cell #(
      .POS   (k),
      .POS_W (PosW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .src_count_i (src_count_q),
      .item_i      (chain[k]),
      .pos_i       (pos_row[k]),
      .item_o      (chain[k+1]),
      .pos_o       (pos_row[k+1])
    );
  end

  // target lookup and output register
  bt_lookup #(
    .TARGET_DEPTH (TARGET_DEPTH),
    .POS_W        (PosW)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tgt_count_i (tgt_count_q),
    .item_i      (chain[SOURCE_DEPTH]),
    .pos_i       (pos_row[SOURCE_DEPTH]),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o)
  );

endmodule
